// File: rtl/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg
// Shared types and constants for the motion occupancy timer.
// ----------------------------------------------------------------------------
package mot_pkg;

  localparam int unsigned CntW  = 24;
  localparam int unsigned MinW  = 8;
  localparam int unsigned TpmW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegPinInverted   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTriggerMin    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAutoOffMin    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTicksPerMin   = 2'd3;

  localparam logic [MinW-1:0] TriggerMinReset = 8'd1;
  localparam logic [MinW-1:0] AutoOffMinReset = 8'd0;
  localparam logic [TpmW-1:0] TicksPerMinReset = 16'd600;

  typedef struct packed {
    logic            pin_inverted;
    logic [MinW-1:0] trigger_minutes;
    logic [MinW-1:0] auto_off_minutes;
    logic [TpmW-1:0] ticks_per_minute;
  } cfg_t;

  typedef struct packed {
    logic            occupied;
    logic            trig_run;
    logic [CntW-1:0] trig_rem;
    logic            ao_run;
    logic [CntW-1:0] ao_rem;
    logic            ao_flag;
  } state_t;

  typedef struct packed {
    logic motion_active;
    logic auto_off_active;
    logic motion_rose;
    logic motion_fell;
    logic auto_off_fired;
    logic auto_on_fired;
  } res_t;

endpackage

// File: rtl/mot_ifs.sv
// ----------------------------------------------------------------------------
// mot_ifs
// Request channels of the motion occupancy timer: poll ticks, results and
// register writes.
// ----------------------------------------------------------------------------
interface mot_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface mot_res_if;
  logic valid;
  logic ready;
  logic motion_active;
  logic auto_off_active;
  logic motion_rose;
  logic motion_fell;
  logic auto_off_fired;
  logic auto_on_fired;

  modport source (output valid, output motion_active, output auto_off_active,
                  output motion_rose, output motion_fell, output auto_off_fired,
                  output auto_on_fired, input ready);
  modport sink   (input valid, input motion_active, input auto_off_active,
                  input motion_rose, input motion_fell, input auto_off_fired,
                  input auto_on_fired, output ready);
endinterface

interface mot_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mot_step.sv
// ----------------------------------------------------------------------------
// mot_step
// Next-state and result logic for one poll tick: timer countdown, expiry,
// retrigger and auto-off/auto-on handling.
// ----------------------------------------------------------------------------
module mot_step (
  input  mot_pkg::cfg_t   cfg_i,
  input  mot_pkg::state_t st_i,
  input  logic            pin_level_i,
  output mot_pkg::state_t st_o,
  output mot_pkg::res_t   res_o
);
  import mot_pkg::*;

  logic [CntW-1:0] prod_trig;
  logic [CntW-1:0] prod_auto;
  logic [CntW-1:0] len_trig;
  logic [CntW-1:0] len_auto;
  logic            active;
  logic            auto_en;
  state_t          st;
  res_t            res;

  assign prod_trig = CntW'(cfg_i.trigger_minutes) * CntW'(cfg_i.ticks_per_minute);
  assign prod_auto = CntW'(cfg_i.auto_off_minutes) * CntW'(cfg_i.ticks_per_minute);
  assign len_trig  = (prod_trig == '0) ? CntW'(1) : prod_trig;
  assign len_auto  = (prod_auto == '0) ? CntW'(1) : prod_auto;
  assign active    = pin_level_i ^ cfg_i.pin_inverted;
  assign auto_en   = (cfg_i.auto_off_minutes != '0);

  always_comb begin
    st  = st_i;
    res = '0;

    if (st_i.ao_run) begin
      if (st_i.ao_rem != '0) begin
        st.ao_rem = st_i.ao_rem - CntW'(1);
      end
      if (st_i.ao_rem <= CntW'(1)) begin
        st.ao_run          = 1'b0;
        st.ao_flag         = 1'b1;
        res.auto_off_fired = 1'b1;
      end
    end

    if (st_i.trig_run) begin
      if (st_i.trig_rem != '0) begin
        st.trig_rem = st_i.trig_rem - CntW'(1);
      end
      if (st_i.trig_rem <= CntW'(1)) begin
        st.trig_run     = 1'b0;
        st.occupied     = 1'b0;
        res.motion_fell = 1'b1;
        if (auto_en && !st.ao_flag) begin
          st.ao_rem = len_auto;
          st.ao_run = 1'b1;
        end
      end
    end

    if (active) begin
      st.trig_rem = len_trig;
      st.trig_run = 1'b1;
      if (auto_en) begin
        st.ao_run = 1'b0;
        st.ao_rem = '0;
      end
      if (!st.occupied) begin
        st.occupied     = 1'b1;
        res.motion_rose = 1'b1;
        if (auto_en && st.ao_flag) begin
          st.ao_flag        = 1'b0;
          res.auto_on_fired = 1'b1;
        end
      end
    end

    res.motion_active   = st.occupied;
    res.auto_off_active = st.ao_flag;
  end

  assign st_o  = st;
  assign res_o = res;

endmodule

// File: rtl/motion_occupancy_timer_core.sv
// ----------------------------------------------------------------------------
// motion_occupancy_timer_core
// Retriggerable occupancy timeout with auto-off for a polled motion pin.
//
//   channel  dir  payload                                       request moves
//   in_i     in   pin_level                                     one poll tick
//   res_o    out  motion_active, auto_off_active, motion_rose,  one result
//                 motion_fell, auto_off_fired, auto_on_fired
//   cfg_i    in   index (2 bits), data (16 bits)                one register
//
// One tick per clock sustained while results are taken; each tick passes
// through the input register, then the result register holding the new state.
// Reset clears the timers, flags and handshake state; registers take their
// reset values. A stalled result holds in the result register while one more
// tick waits in the input register; ticks are refused only when both are full.
// Register writes are taken in every cycle.
// ----------------------------------------------------------------------------
module motion_occupancy_timer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mot_in_if.sink     in_i,
  mot_res_if.source  res_o,
  mot_cfg_if.sink    cfg_i
);
  import mot_pkg::*;

  cfg_t   cfg_q;
  state_t st_q;
  state_t st_d;
  res_t   res_q;
  res_t   res_d;
  logic   in_valid_q;
  logic   pin_q;
  logic   out_valid_q;
  logic   adv;
  logic   in_acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_inverted     <= 1'b0;
      cfg_q.trigger_minutes  <= TriggerMinReset;
      cfg_q.auto_off_minutes <= AutoOffMinReset;
      cfg_q.ticks_per_minute <= TicksPerMinReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegPinInverted: cfg_q.pin_inverted     <= cfg_i.data[0];
        RegTriggerMin:  cfg_q.trigger_minutes  <= cfg_i.data[MinW-1:0];
        RegAutoOffMin:  cfg_q.auto_off_minutes <= cfg_i.data[MinW-1:0];
        RegTicksPerMin: cfg_q.ticks_per_minute <= cfg_i.data[TpmW-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_q || res_o.ready;
  assign in_i.ready = !in_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  mot_step u_step (
    .cfg_i       (cfg_q),
    .st_i        (st_q),
    .pin_level_i (pin_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pin_q <= in_i.pin_level;
    end
    if (adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.motion_active   = res_q.motion_active;
  assign res_o.auto_off_active = res_q.auto_off_active;
  assign res_o.motion_rose     = res_q.motion_rose;
  assign res_o.motion_fell     = res_q.motion_fell;
  assign res_o.auto_off_fired  = res_q.auto_off_fired;
  assign res_o.auto_on_fired   = res_q.auto_on_fired;

  a_occ_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.occupied == st_q.trig_run)
    else $error("occupancy and trigger timer disagree");

  a_flag_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.ao_run && st_q.ao_flag))
    else $error("auto-off timer running while flag set");

  a_on_rose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.auto_on_fired |-> res_q.motion_rose && !res_q.auto_off_active)
    else $error("auto-on without motion rising");

  a_off_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.auto_off_fired && !res_q.auto_on_fired |-> res_q.auto_off_active)
    else $error("auto-off fired without flag");

  a_fell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.motion_fell && !res_q.motion_rose |-> !res_q.motion_active)
    else $error("occupancy fell but still active");

endmodule

// File: tb/tb_motion_occupancy_timer_core.sv
// ----------------------------------------------------------------------------
// tb_motion_occupancy_timer_core
// Drives poll ticks, register writes and result back-pressure into the motion
// occupancy timer. A scoreboard holds its own copy of the timers and flags,
// predicts the report for every accepted tick, and checks each accepted
// result against the oldest predicted report. A directed opening covers
// retrigger, expiry, auto-off, auto-on, zero lengths and inversion. Random
// phases follow, each with fresh register values, built mostly from motion
// bursts and quiet stretches, some of them long enough to run both timers out.
// ----------------------------------------------------------------------------
module tb_motion_occupancy_timer_core;
  import mot_pkg::*;

  localparam int unsigned StallLimit = 2000;

  class occupancy_tracker;
    cfg_t        regs;
    state_t      st;
    res_t        expected_reports[$];
    int unsigned faults;
    int unsigned checked;

    function new();
      regs.pin_inverted     = 1'b0;
      regs.trigger_minutes  = TriggerMinReset;
      regs.auto_off_minutes = AutoOffMinReset;
      regs.ticks_per_minute = TicksPerMinReset;
      st      = '0;
      faults  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegPinInverted: regs.pin_inverted     = data[0];
        RegTriggerMin:  regs.trigger_minutes  = data[MinW-1:0];
        RegAutoOffMin:  regs.auto_off_minutes = data[MinW-1:0];
        RegTicksPerMin: regs.ticks_per_minute = data[TpmW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CntW-1:0] span(logic [MinW-1:0] minutes);
      logic [31:0] product;
      product = 32'(minutes) * 32'(regs.ticks_per_minute);
      if (product > 32'hFF_FFFF) product = 32'hFF_FFFF;
      if (product == '0) product = 32'd1;
      return product[CntW-1:0];
    endfunction

    function void take_tick(logic pin);
      res_t rep;
      logic active;
      rep    = '0;
      active = pin ^ regs.pin_inverted;
      if (st.ao_run) begin
        if (st.ao_rem != '0) st.ao_rem--;
        if (st.ao_rem == '0) begin
          st.ao_run          = 1'b0;
          st.ao_flag         = 1'b1;
          rep.auto_off_fired = 1'b1;
        end
      end
      if (st.trig_run) begin
        if (st.trig_rem != '0) st.trig_rem--;
        if (st.trig_rem == '0) begin
          st.trig_run     = 1'b0;
          st.occupied     = 1'b0;
          rep.motion_fell = 1'b1;
          if (regs.auto_off_minutes != '0 && !st.ao_flag) begin
            st.ao_rem = span(regs.auto_off_minutes);
            st.ao_run = 1'b1;
          end
        end
      end
      if (active) begin
        st.trig_rem = span(regs.trigger_minutes);
        st.trig_run = 1'b1;
        if (regs.auto_off_minutes != '0) begin
          st.ao_run = 1'b0;
          st.ao_rem = '0;
        end
        if (!st.occupied) begin
          st.occupied     = 1'b1;
          rep.motion_rose = 1'b1;
          if (regs.auto_off_minutes != '0 && st.ao_flag) begin
            st.ao_flag        = 1'b0;
            rep.auto_on_fired = 1'b1;
          end
        end
      end
      rep.motion_active   = st.occupied;
      rep.auto_off_active = st.ao_flag;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(res_t got);
      res_t want;
      bit   bad;
      checked++;
      if (expected_reports.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("report %0d arrived with nothing expected: %b", checked, got);
        return;
      end
      want = expected_reports.pop_front();
      bad  = 1'b0;
      for (int f = 0; f < $bits(res_t); f++)
        if (got[f] !== want[f]) bad = 1'b1;
      if (bad) begin
        faults++;
        if (faults <= 10)
          $display("report %0d mismatch: expected %b got %b", checked, want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mot_in_if  tick_if();
  mot_res_if report_if();
  mot_cfg_if reg_if();

  occupancy_tracker tracker = new();

  logic        sink_ready = 1'b0;
  int unsigned sink_left  = 0;
  int unsigned sink_mode  = 0;
  int unsigned burst_left = 0;
  int unsigned stuck      = 0;

  assign report_if.ready = sink_ready;

  motion_occupancy_timer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .res_o  (report_if),
    .cfg_i  (reg_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (report_if.valid && report_if.ready) begin
        tracker.check_report('{motion_active:   report_if.motion_active,
                               auto_off_active: report_if.auto_off_active,
                               motion_rose:     report_if.motion_rose,
                               motion_fell:     report_if.motion_fell,
                               auto_off_fired:  report_if.auto_off_fired,
                               auto_on_fired:   report_if.auto_on_fired});
      end
      if (tick_if.valid && tick_if.ready) tracker.take_tick(tick_if.pin_level);
      if (reg_if.valid && reg_if.ready) tracker.write_reg(reg_if.index, reg_if.data);
    end
  end

  // free flow, choppy, or mostly stalled
  always @(posedge clk_i) begin
    if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else begin
      if ($urandom_range(0, 15) == 0) sink_mode <= $urandom_range(0, 2);
      case (sink_mode)
        0: begin
          sink_ready <= 1'b1;
          sink_left  <= $urandom_range(20, 200);
        end
        1: begin
          sink_ready <= 1'($urandom_range(0, 1));
          sink_left  <= $urandom_range(0, 3);
        end
        default: begin
          sink_ready <= ($urandom_range(0, 3) == 0);
          sink_left  <= $urandom_range(0, 12);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tick_if.valid && tick_if.ready) || (report_if.valid && report_if.ready)
        || (reg_if.valid && reg_if.ready)) begin
      stuck <= 0;
    end else if (stuck == StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 12);
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick(input logic pin);
    tick_if.valid     <= 1'b1;
    tick_if.pin_level <= pin;
    do @(posedge clk_i); while (!tick_if.ready);
    pace();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
  endtask

  task automatic set_regs(input logic inv, input logic [MinW-1:0] trig_min,
                          input logic [MinW-1:0] off_min, input logic [TpmW-1:0] tpm);
    write_reg(RegPinInverted, {15'($urandom), inv});
    write_reg(RegTriggerMin, {8'($urandom), trig_min});
    write_reg(RegAutoOffMin, {8'($urandom), off_min});
    write_reg(RegTicksPerMin, tpm);
    reg_if.valid <= 1'b0;
  endtask

  // drain every outstanding report, then let the pipeline settle
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int unsigned tick_span(int unsigned minutes, int unsigned tpm);
    return (minutes * tpm == 0) ? 1 : minutes * tpm;
  endfunction

  task automatic run_phase(input logic inv, input logic [MinW-1:0] trig_min,
                           input logic [MinW-1:0] off_min, input logic [TpmW-1:0] tpm,
                           input int unsigned count);
    int unsigned sent;
    int unsigned cycle_len;
    int unsigned run;
    int unsigned quiet;
    wait_idle();
    set_regs(inv, trig_min, off_min, tpm);
    cycle_len = tick_span(trig_min, tpm) + ((off_min != 0) ? tick_span(off_min, tpm) : 0);
    if (cycle_len > 600) cycle_len = 600;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        run   = $urandom_range(1, 4);
        quiet = ($urandom_range(0, 1) != 0) ? cycle_len + $urandom_range(0, 3)
                                            : $urandom_range(0, cycle_len);
        if (sent + run >= count) quiet = 0;
        else if (quiet > count - sent - run) quiet = count - sent - run;
        repeat (run) send_tick(~inv);
        repeat (quiet) send_tick(inv);
        sent += run + quiet;
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) send_tick(1'($urandom));
        sent += run;
      end
    end
  endtask

  initial begin
    logic             inv;
    logic [MinW-1:0]  trig_min;
    logic [MinW-1:0]  off_min;
    logic [TpmW-1:0]  tpm;
    tick_if.valid     <= 1'b0;
    tick_if.pin_level <= 1'b0;
    reg_if.valid      <= 1'b0;
    reg_if.index      <= RegPinInverted;
    reg_if.data       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: retrigger without expiry
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    // one-tick timers: fall, auto-off, auto-on, and fall with rise together
    wait_idle();
    set_regs(1'b0, 8'd1, 8'd1, 16'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    // zero lengths, auto-off disabled while its timer still runs
    wait_idle();
    set_regs(1'b0, 8'd0, 8'd0, 16'd0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    // inverted pin; disable auto-off mid-countdown
    wait_idle();
    set_regs(1'b1, 8'd1, 8'd2, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
    set_regs(1'b1, 8'd1, 8'd0, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    run_phase(1'b1, 8'd255, 8'd255, 16'd1, 600);
    run_phase(1'b0, 8'd1, 8'd0, 16'hFFFF, 20);
    run_phase(1'b0, 8'd0, 8'd255, 16'd0, 60);
    for (int p = 0; p < 14; p++) begin
      inv = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       tpm = '0;
        1:       tpm = TpmW'($urandom_range(0, 65535));
        default: tpm = TpmW'($urandom_range(1, 3));
      endcase
      trig_min = ($urandom_range(0, 4) == 0) ? MinW'($urandom_range(0, 255))
                                            : MinW'($urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: off_min = '0;
        4:          off_min = 8'd255;
        default:    off_min = MinW'($urandom_range(1, 5));
      endcase
      run_phase(inv, trig_min, off_min, tpm, 90);
    end

    wait_idle();
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mot_pkg.sv
rtl/mot_ifs.sv
rtl/mot_step.sv
rtl/motion_occupancy_timer_core.sv
tb/tb_motion_occupancy_timer_core.sv
